// ----- sv/tcf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, constants and the CORDIC arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW       = $clog2(CordicSteps + 1);

    localparam logic [15:0] StepTimeRst = 16'd655;
    localparam logic [15:0] GainRst     = 16'd1311;
    localparam logic [15:0] CalibRst    = 16'd50;

    localparam logic [1:0] RegStepTime = 2'd0;
    localparam logic [1:0] RegGain     = 2'd1;
    localparam logic [1:0] RegCalib    = 2'd2;

    localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
    localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
    localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
    localparam logic signed [35:0] OneQ30    = 36'sd1073741824;
    localparam logic signed [19:0] PiU13     = 20'sd25736;
    localparam logic signed [19:0] TwoPiU13  = 20'sd51472;

    typedef enum logic [3:0] {
        S_IDLE, S_CAL_DIV, S_PRED_MUL, S_PRED_ADD, S_ROT_PREP, S_ROT,
        S_DOT_MUL, S_VEC_PREP, S_VEC, S_GAIN_MUL, S_TIME_MUL, S_WRAP, S_DONE
    } t_state;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] gyro_rate;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
    } t_item;

    typedef struct packed {
        logic signed [15:0] tilt_angle;
        logic signed [15:0] corrected_rate;
    } t_result;

    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 36'h03243F6A8;
            5'd1:  atan_q30 = 36'h01DAC6705;
            5'd2:  atan_q30 = 36'h00FADBAFC;
            5'd3:  atan_q30 = 36'h007F56EA6;
            5'd4:  atan_q30 = 36'h003FEAB76;
            5'd5:  atan_q30 = 36'h001FFD55B;
            5'd6:  atan_q30 = 36'h000FFFAAA;
            5'd7:  atan_q30 = 36'h0007FFF55;
            5'd8:  atan_q30 = 36'h0003FFFEA;
            5'd9:  atan_q30 = 36'h0001FFFFD;
            5'd10: atan_q30 = 36'h0000FFFFF;
            5'd11: atan_q30 = 36'h00007FFFF;
            5'd12: atan_q30 = 36'h00003FFFF;
            5'd13: atan_q30 = 36'h00001FFFF;
            5'd14: atan_q30 = 36'h00000FFFF;
            5'd15: atan_q30 = 36'h000007FFF;
            5'd16: atan_q30 = 36'h000003FFF;
            5'd17: atan_q30 = 36'h000001FFF;
            5'd18: atan_q30 = 36'h000000FFF;
            5'd19: atan_q30 = 36'h0000007FF;
            5'd20: atan_q30 = 36'h0000003FF;
            5'd21: atan_q30 = 36'h0000001FF;
            5'd22: atan_q30 = 36'h0000000FF;
            5'd23: atan_q30 = 36'h00000007F;
            default: atan_q30 = '0;
        endcase
    endfunction

endpackage

// ----- sv/tcf_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_stream_if
// Valid/ready channel carrying a payload of a chosen type.
// ----------------------------------------------------------------------------
interface tcf_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/tcf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_front
// Input side: accepts items into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tcf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tcf_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output tcf_pkg::t_item o_item
);
    tcf_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !w_pop) else $error("pop from empty queue");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> r_cnt == 2'd2) else $error("full lost");
endmodule

// ----- sv/tcf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_back
// Filter engine: calibration divide, predict, CORDIC sin/cos and atan2,
// correction and wrap, sequenced over many cycles with one result register.
// ----------------------------------------------------------------------------
module tcf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tcf_pkg::t_item  i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output tcf_pkg::t_result o_result,
    input  logic [15:0]     i_step_time,
    input  logic [15:0]     i_gain,
    input  logic [15:0]     i_calib
);
    tcf_pkg::t_state r_state, n_state;
    tcf_pkg::t_item  r_item;
    logic signed [17:0] r_angle;
    logic signed [31:0] r_bias;
    logic signed [15:0] r_last;
    logic signed [33:0] r_diff;
    logic signed [51:0] r_prod;
    logic signed [19:0] r_ang;
    logic signed [35:0] r_x, r_y, r_z;
    logic               r_flip;
    logic [tcf_pkg::StepW-1:0] r_i;
    logic signed [52:0] r_px1, r_px2, r_py1, r_py2;
    logic signed [63:0] r_vx, r_vy;
    logic signed [35:0] r_err;
    logic signed [52:0] r_t;
    logic signed [31:0] r_num;  // |gyro<<16| divided by calib, restoring
    logic [31:0]        r_rem, r_quo;
    logic [5:0]         r_dcnt;
    logic               r_res_valid;
    tcf_pkg::t_result   r_res;

    logic signed [35:0] w_z1;
    logic signed [36:0] w_sx, w_sy;
    logic signed [65:0] w_vsx, w_vsy;
    logic [32:0]        w_trial;
    logic [15:0]        w_den;
    logic signed [32:0] w_q;
    logic signed [33:0] w_bsum;
    logic [4:0]         w_ti;
    logic signed [63:0] w_dot, w_cross;

    assign o_ready  = (r_state == tcf_pkg::S_IDLE);
    assign o_valid  = r_res_valid;
    assign o_result = r_res;
    assign w_den    = (i_calib == 16'd0) ? 16'd1 : i_calib;
    assign w_trial  = {r_rem[31:0], r_num[31]} ;
    assign w_ti     = 5'(r_i);
    assign w_dot    = 64'(r_px1) + 64'(r_px2);
    assign w_cross  = 64'(r_py1) - 64'(r_py2);

    always_comb begin
        // Fold into the right half plane; the result is negated at the end.
        w_z1 = r_z;
        if (r_z > tcf_pkg::HalfPiQ30) w_z1 = r_z - tcf_pkg::PiQ30;
        else if (r_z < -tcf_pkg::HalfPiQ30) w_z1 = r_z + tcf_pkg::PiQ30;
        w_sx  = 37'(r_x) >>> r_i;
        w_sy  = 37'(r_y) >>> r_i;
        w_vsx = 66'(r_vx) >>> r_i;
        w_vsy = 66'(r_vy) >>> r_i;
        w_q   = r_item.gyro_rate[15] ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        w_bsum = 34'(r_bias) + 34'(w_q);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcf_pkg::S_IDLE:     if (i_valid) n_state = i_item.cmd ? tcf_pkg::S_PRED_MUL
                                                               : tcf_pkg::S_CAL_DIV;
            tcf_pkg::S_CAL_DIV:  if (r_dcnt == 6'd32) n_state = tcf_pkg::S_DONE;
            tcf_pkg::S_PRED_MUL: n_state = tcf_pkg::S_PRED_ADD;
            tcf_pkg::S_PRED_ADD: n_state = tcf_pkg::S_ROT_PREP;
            tcf_pkg::S_ROT_PREP: if (r_z <= tcf_pkg::PiQ30 && r_z >= -tcf_pkg::PiQ30)
                                     n_state = tcf_pkg::S_ROT;
            tcf_pkg::S_ROT:      if (r_i == tcf_pkg::StepW'(tcf_pkg::CordicSteps - 1))
                                     n_state = tcf_pkg::S_DOT_MUL;
            tcf_pkg::S_DOT_MUL:  n_state = tcf_pkg::S_VEC_PREP;
            tcf_pkg::S_VEC_PREP: n_state = (w_dot == 0 && w_cross == 0) ? tcf_pkg::S_GAIN_MUL
                                                                        : tcf_pkg::S_VEC;
            tcf_pkg::S_VEC:      if (r_i == tcf_pkg::StepW'(tcf_pkg::CordicSteps - 1))
                                     n_state = tcf_pkg::S_GAIN_MUL;
            tcf_pkg::S_GAIN_MUL: n_state = tcf_pkg::S_TIME_MUL;
            tcf_pkg::S_TIME_MUL: n_state = tcf_pkg::S_WRAP;
            tcf_pkg::S_WRAP:     n_state = tcf_pkg::S_DONE;
            tcf_pkg::S_DONE:     if (!r_res_valid || i_ready) n_state = tcf_pkg::S_IDLE;
            default:             n_state = tcf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic signed [63:0] v_rnd;
        logic signed [53:0] v_ang;
        logic signed [17:0] v_sat;
        v_rnd = '0; v_ang = '0; v_sat = '0;
        if (!i_rst_n) begin
            r_state <= tcf_pkg::S_IDLE;
            r_angle <= '0; r_bias <= '0; r_last <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_res_valid && i_ready) r_res_valid <= 1'b0;
            case (r_state)
                tcf_pkg::S_IDLE: if (i_valid) begin
                    r_item <= i_item;
                    r_num  <= i_item.gyro_rate[15] ? -(32'(i_item.gyro_rate) <<< 16)
                                                   : (32'(i_item.gyro_rate) <<< 16);
                    r_rem <= '0; r_quo <= '0; r_dcnt <= '0;
                    r_diff <= (34'(i_item.gyro_rate) <<< 16) - 34'(r_bias);
                end
                tcf_pkg::S_CAL_DIV: begin
                    if (r_dcnt != 6'd32) begin
                        if (w_trial >= {17'd0, w_den}) begin
                            r_rem <= 32'(w_trial - {17'd0, w_den});
                            r_quo <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_rem <= w_trial[31:0];
                            r_quo <= {r_quo[30:0], 1'b0};
                        end
                        r_num  <= r_num <<< 1;
                        r_dcnt <= r_dcnt + 6'd1;
                    end else begin
                        r_bias <= (w_bsum > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                                  (w_bsum < -34'sh080000000) ? 32'sh80000000 : 32'(w_bsum);
                    end
                end
                tcf_pkg::S_PRED_MUL: begin
                    r_prod <= 52'(r_diff) * $signed({1'b0, i_step_time});
                    v_rnd = (64'(r_diff) + 64'sd32768) >>> 16;
                    r_last <= (v_rnd > 64'sd32767) ? 16'sh7FFF :
                              (v_rnd < -64'sd32768) ? 16'sh8000 : 16'(v_rnd);
                end
                tcf_pkg::S_PRED_ADD: begin
                    v_ang = 54'(r_angle) + ((54'(r_prod) + (54'sd1 <<< 28)) >>> 29);
                    if (v_ang > 54'sd131071) v_ang = 54'sd131071;
                    else if (v_ang < -54'sd131072) v_ang = -54'sd131072;
                    r_ang <= 20'(v_ang);
                    r_z   <= 36'(v_ang) <<< 17;
                end
                tcf_pkg::S_ROT_PREP: begin
                    // Reduce by 2*pi one step a cycle, then start the rotation.
                    if (r_z > tcf_pkg::PiQ30) begin
                        r_z <= r_z - tcf_pkg::TwoPiQ30;
                    end else if (r_z < -tcf_pkg::PiQ30) begin
                        r_z <= r_z + tcf_pkg::TwoPiQ30;
                    end else begin
                        r_flip <= (r_z > tcf_pkg::HalfPiQ30) || (r_z < -tcf_pkg::HalfPiQ30);
                        r_z <= w_z1; r_x <= tcf_pkg::OneQ30; r_y <= '0; r_i <= '0;
                    end
                end
                tcf_pkg::S_ROT: begin
                    if (!r_z[35]) begin
                        r_x <= 36'(37'(r_x) - w_sy); r_y <= 36'(37'(r_y) + w_sx);
                        r_z <= r_z - tcf_pkg::atan_q30(w_ti);
                    end else begin
                        r_x <= 36'(37'(r_x) + w_sy); r_y <= 36'(37'(r_y) - w_sx);
                        r_z <= r_z + tcf_pkg::atan_q30(w_ti);
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == tcf_pkg::StepW'(tcf_pkg::CordicSteps - 1) && r_flip) begin
                        r_x <= -36'(37'(r_x) - (r_z[35] ? -w_sy : w_sy));
                        r_y <= -36'(37'(r_y) + (r_z[35] ? -w_sx : w_sx));
                    end
                end
                tcf_pkg::S_DOT_MUL: begin
                    r_px1 <= 53'(r_x) * 53'(r_item.accel_x);
                    r_px2 <= 53'(r_y) * 53'(r_item.accel_y);
                    r_py1 <= 53'(r_x) * 53'(r_item.accel_y);
                    r_py2 <= 53'(r_y) * 53'(r_item.accel_x);
                    r_vx <= '0; r_vy <= '0;
                end
                tcf_pkg::S_VEC_PREP: begin
                    r_i <= '0; r_err <= '0;
                    if (w_dot < 0) begin
                        r_vx  <= -w_dot;
                        r_vy  <= -w_cross;
                        r_err <= (w_cross >= 0) ? tcf_pkg::PiQ30 : -tcf_pkg::PiQ30;
                    end else begin
                        r_vx <= w_dot;
                        r_vy <= w_cross;
                    end
                end
                tcf_pkg::S_VEC: begin
                    if (r_vy > 0) begin
                        r_vx <= 64'(66'(r_vx) + w_vsy); r_vy <= 64'(66'(r_vy) - w_vsx);
                        r_err <= r_err + tcf_pkg::atan_q30(w_ti);
                    end else begin
                        r_vx <= 64'(66'(r_vx) - w_vsy); r_vy <= 64'(66'(r_vy) + w_vsx);
                        r_err <= r_err - tcf_pkg::atan_q30(w_ti);
                    end
                    r_i <= r_i + 1'b1;
                end
                tcf_pkg::S_GAIN_MUL: begin
                    r_t <= (53'(r_err) * $signed({1'b0, i_gain}) + 53'sd32768) >>> 16;
                end
                tcf_pkg::S_TIME_MUL: begin
                    r_prod <= 52'(r_t) * $signed({1'b0, i_step_time});
                end
                tcf_pkg::S_WRAP: begin
                    v_ang = 54'(r_ang) + ((54'(r_prod) + (54'sd1 <<< 32)) >>> 33);
                    if (v_ang > 54'(tcf_pkg::PiU13)) v_ang = v_ang - 54'(tcf_pkg::TwoPiU13);
                    else if (v_ang < -54'(tcf_pkg::PiU13))
                        v_ang = v_ang + 54'(tcf_pkg::TwoPiU13);
                    r_angle <= (v_ang > 54'sd131071) ? 18'sd131071 :
                               (v_ang < -54'sd131072) ? -18'sd131072 : 18'(v_ang);
                end
                tcf_pkg::S_DONE: if (!r_res_valid || i_ready) begin
                    r_res_valid <= 1'b1;
                    v_sat = r_angle;
                    r_res.tilt_angle <= (v_sat > 18'(tcf_pkg::PiU13)) ? 16'(tcf_pkg::PiU13) :
                                        (v_sat < -18'(tcf_pkg::PiU13)) ? -16'(tcf_pkg::PiU13)
                                                                      : 16'(v_sat);
                    r_res.corrected_rate <= r_last;
                end
                default: ;
            endcase
        end
    end

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == tcf_pkg::S_IDLE) else $error("ready outside idle");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_result)) else $error("result lost");
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.tilt_angle <= 16'sd25736 && o_result.tilt_angle >= -16'sd25736))
        else $error("angle out of range");
endmodule

// ----- sv/tilt_complementary_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_complementary_filter_core
// One-axis tilt estimator: gyro bias calibration and complementary filter.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   cmd, gyro_rate, accel_x, accel_y
//  out_ch    out  tilt_angle, corrected_rate
//  cfg       in   i_cfg_we, i_cfg_idx[1:0], i_cfg_data[15:0]
// Estimate item: two 16-step CORDIC passes (the second skipped when the
// rotated accel vector is zero), after reducing the predicted angle by 2*pi.
// Calibration item: runs through the bit-serial bias divider.
// One item is in the engine at a time; a two-entry queue takes new items.
// Reset is synchronous, active low; it restores registers and clears state.
// A stalled result register holds the engine in its last state.
module tilt_complementary_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcf_stream_if.sink   in_ch,
    tcf_stream_if.source out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] r_step_time, r_gain, r_calib;
    logic           w_q_valid, w_q_ready;
    tcf_pkg::t_item w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= tcf_pkg::StepTimeRst;
            r_gain      <= tcf_pkg::GainRst;
            r_calib     <= tcf_pkg::CalibRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcf_pkg::RegStepTime: r_step_time <= i_cfg_data;
                tcf_pkg::RegGain:     r_gain      <= i_cfg_data;
                tcf_pkg::RegCalib:    r_calib     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcf_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_item(in_ch.data),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_item(w_q_item)
    );

    tcf_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_item(w_q_item),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_result(out_ch.data),
        .i_step_time(r_step_time), .i_gain(r_gain), .i_calib(r_calib)
    );
endmodule
